// ===== hw/rtl/cooperative_task_scheduler_table_core_defines.svh =====
// Assertion macros shared by the scheduler table checker.
`ifndef COOPERATIVE_TASK_SCHEDULER_TABLE_CORE_DEFINES_SVH
`define COOPERATIVE_TASK_SCHEDULER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cts_pkg.sv =====
// Shared types and constants of the cooperative task scheduler table.
package cts_pkg;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_DELETE   = 2'd2,
		MODE_DISPATCH = 2'd3
	} mode_t;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_DELETED = 3'd2;
	localparam logic [2:0] KIND_TICKED  = 3'd3;
	localparam logic [2:0] KIND_RUN     = 3'd4;
	localparam logic [2:0] KIND_IDLE    = 3'd5;

	localparam logic [7:0] RUN_LIMIT   = 8'd255;
	localparam logic [3:0] MAX_RESULTS = 4'd8;

	// One table entry as kept in the slot memory.
	typedef struct packed {
		logic [15:0] countdown;
		logic [15:0] period;
		logic [7:0]  pending;
	} slot_rec_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;
		logic rd_en;
		logic finish;
	} cts_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic hold_up;
		logic out_free;
		logic v_s1;
	} cts_sts_t;

endpackage

// ===== hw/rtl/cts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cts_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/cts_ctrl.sv =====
// Controller state machine: accepts requests and sequences the slot walk.
module cts_ctrl #(
	parameter int TASK_SLOTS = 8,
	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
	localparam int CNT_W  = $clog2(TASK_SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  cts_pkg::cts_sts_t sts,
	output cts_pkg::cts_cmd_t cmd,
	output logic [SLOT_W-1:0] rd_addr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(TASK_SLOTS);

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.start  = in_valid && (state_q == ST_IDLE);
	assign cmd.rd_en  = (state_q == ST_WALK) && (idx_q < SLOT_END) && !sts.hold_up;
	assign cmd.finish = (state_q == ST_FINISH) && sts.out_free;
	assign rd_addr    = idx_q[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						idx_q <= '0;
						if (mode == cts_pkg::MODE_DELETE) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (cmd.rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if ((idx_q == SLOT_END) && !sts.v_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/cts_datapath.sv =====
// Datapath: slot memory, used flags, update stage and result registers.
module cts_datapath #(
	parameter int TASK_SLOTS = 8,
	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        mode,
	input  logic [2:0]        task_slot,
	input  logic [15:0]       start_delay,
	input  logic [15:0]       repeat_period,
	input  cts_pkg::cts_cmd_t cmd,
	input  logic [SLOT_W-1:0] rd_addr,
	output cts_pkg::cts_sts_t sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        kind,
	output logic [2:0]        slot_index,
	output logic              last
);

	localparam int REC_W = $bits(cts_pkg::slot_rec_t);

	// Request registers.
	cts_pkg::mode_t mode_q;
	logic [2:0]     sel_q;
	logic [15:0]    delay_q;
	logic [15:0]    period_q;

	// Walk state.
	logic [TASK_SLOTS-1:0] used_q;
	logic                  v_s1;
	logic [SLOT_W-1:0]     addr_s1;
	logic                  found_q;
	logic [2:0]            found_slot_q;
	logic [3:0]            cnt_q;
	logic                  hold_v_q;
	logic [2:0]            hold_slot_q;

	// Result register.
	logic       out_v_q;
	logic [2:0] out_kind_q;
	logic [2:0] out_slot_q;
	logic       out_last_q;

	logic [REC_W-1:0]   rd_data;
	cts_pkg::slot_rec_t rec;
	cts_pkg::slot_rec_t wrec;
	logic               we;
	logic               used_s1;
	logic [7:0]         pend_eff;
	logic               run_hit;
	logic               go_s1;
	logic               set_used;
	logic               clr_used;
	logic               mid_push;
	logic               del_hit;

	cts_ram #(
		.WIDTH (REC_W),
		.DEPTH (TASK_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wrec),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign rec      = cts_pkg::slot_rec_t'(rd_data);
	assign used_s1  = used_q[addr_s1];
	// A free slot reads as empty, whatever the memory holds.
	assign pend_eff = used_s1 ? rec.pending : 8'd0;
	assign run_hit  = v_s1 && (mode_q == cts_pkg::MODE_DISPATCH) && (pend_eff != 8'd0)
		&& (cnt_q < cts_pkg::MAX_RESULTS);
	assign sts.hold_up  = run_hit && hold_v_q && out_v_q && out_stall;
	assign sts.out_free = !out_v_q || !out_stall;
	assign sts.v_s1     = v_s1;
	assign go_s1    = v_s1 && !sts.hold_up;
	assign mid_push = go_s1 && run_hit && hold_v_q;
	assign del_hit  = (mode_q == cts_pkg::MODE_DELETE) && (32'(sel_q) < TASK_SLOTS);

	always_comb begin
		we       = 1'b0;
		wrec     = rec;
		set_used = 1'b0;
		clr_used = 1'b0;
		unique case (mode_q)
			cts_pkg::MODE_TICK: begin
				if (go_s1 && used_s1) begin
					we = 1'b1;
					if (rec.countdown <= 16'd1) begin
						if (rec.pending != cts_pkg::RUN_LIMIT) begin
							wrec.pending = rec.pending + 8'd1;
						end
						if (rec.period != 16'd0) begin
							wrec.countdown = rec.period;
						end
					end else begin
						wrec.countdown = rec.countdown - 16'd1;
					end
				end
			end
			cts_pkg::MODE_ADD: begin
				if (go_s1 && !used_s1 && !found_q) begin
					we             = 1'b1;
					set_used       = 1'b1;
					wrec.countdown = delay_q;
					wrec.period    = period_q;
					wrec.pending   = 8'd0;
				end
			end
			cts_pkg::MODE_DISPATCH: begin
				if (go_s1 && run_hit) begin
					wrec.pending = rec.pending - 8'd1;
					if (rec.period == 16'd0) begin
						clr_used = 1'b1;
					end else begin
						we = 1'b1;
					end
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sel_q    <= task_slot;
			delay_q  <= start_delay;
			period_q <= repeat_period;
		end
		if (!sts.hold_up) begin
			addr_s1 <= rd_addr;
		end
		if (set_used) begin
			found_slot_q <= 3'(addr_s1);
		end
		if (go_s1 && run_hit) begin
			hold_slot_q <= 3'(addr_s1);
		end
		if (mid_push) begin
			out_kind_q <= cts_pkg::KIND_RUN;
			out_slot_q <= hold_slot_q;
			out_last_q <= 1'b0;
		end else if (cmd.finish) begin
			out_last_q <= 1'b1;
			unique case (mode_q)
				cts_pkg::MODE_TICK: begin
					out_kind_q <= cts_pkg::KIND_TICKED;
					out_slot_q <= 3'd0;
				end
				cts_pkg::MODE_ADD: begin
					out_kind_q <= found_q ? cts_pkg::KIND_ADDED : cts_pkg::KIND_FULL;
					out_slot_q <= found_q ? found_slot_q : 3'd0;
				end
				cts_pkg::MODE_DELETE: begin
					out_kind_q <= cts_pkg::KIND_DELETED;
					out_slot_q <= sel_q;
				end
				cts_pkg::MODE_DISPATCH: begin
					out_kind_q <= hold_v_q ? cts_pkg::KIND_RUN : cts_pkg::KIND_IDLE;
					out_slot_q <= hold_v_q ? hold_slot_q : 3'd0;
				end
				default: begin
					out_kind_q <= cts_pkg::KIND_IDLE;
					out_slot_q <= 3'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cts_pkg::MODE_TICK;
			used_q   <= '0;
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				mode_q   <= cts_pkg::mode_t'(mode);
				found_q  <= 1'b0;
				cnt_q    <= '0;
				hold_v_q <= 1'b0;
			end
			if (!sts.hold_up) begin
				v_s1 <= cmd.rd_en;
			end
			if (set_used) begin
				used_q[addr_s1] <= 1'b1;
				found_q         <= 1'b1;
			end
			if (clr_used) begin
				used_q[addr_s1] <= 1'b0;
			end
			if (cmd.finish && del_hit) begin
				used_q[SLOT_W'(sel_q)] <= 1'b0;
			end
			if (go_s1 && run_hit) begin
				hold_v_q <= 1'b1;
				cnt_q    <= cnt_q + 4'd1;
			end
			if (cmd.finish) begin
				hold_v_q <= 1'b0;
			end
			if (mid_push || cmd.finish) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign kind       = out_kind_q;
	assign slot_index = out_slot_q;
	assign last       = out_last_q;

endmodule

// ===== hw/rtl/cooperative_task_scheduler_table_core.sv =====
// Top level of the cooperative task scheduler table: controller plus datapath.
//
//   Channel   Direction   Handshake            Payload
//   in        request     in_valid/in_stall    mode, task_slot, start_delay, repeat_period
//   out       result      out_valid/out_stall  kind, slot_index, last
//
// Tick, add and dispatch walk the slots one per cycle through a registered-read memory,
// while no held run result pauses the walk; their result is registered once the walk
// ends, and the next request is taken after that. Delete skips the walk and answers.
// Reset clears all used flags at once; the table memory itself is never cleared.
// A stall on the result side pauses the dispatch walk only when a second run
// result must leave while the previous one still waits in the output register.
module cooperative_task_scheduler_table_core #(
	parameter int TASK_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [2:0]  task_slot,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [2:0]  slot_index,
	output logic        last
);

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	// Commands from the controller and status from the datapath.
	cts_pkg::cts_cmd_t cmd;
	cts_pkg::cts_sts_t sts;
	// Slot address of the memory read that the walk issues this cycle.
	logic [SLOT_W-1:0] rd_addr;

	// The controller decides when a request is taken, steps the slot counter and
	// tells the datapath when the closing result of the request may be written.
	cts_ctrl #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	// The datapath applies the per-slot update to each registered memory read, holds
	// the last run result back until it knows whether another follows, and owns
	// the output register.
	cts_datapath #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.task_slot     (task_slot),
		.start_delay   (start_delay),
		.repeat_period (repeat_period),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.slot_index    (slot_index),
		.last          (last)
	);

endmodule

// ===== hw/rtl/cts_checker.sv =====
// Port-level checker for the scheduler table, bound to the top level.
`include "cooperative_task_scheduler_table_core_defines.svh"

module cts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  mode,
	input logic [2:0]  task_slot,
	input logic [15:0] start_delay,
	input logic [15:0] repeat_period,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [2:0]  slot_index,
	input logic        last
);

	// A stalled result stays and does not change.
	`CTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(slot_index) && $stable(last), "stalled result changed")
	// Only run results may be followed by more results of the same request.
	`CTS_ASSERT_NOW(a_last_kind, clk, arst_n, out_valid && !last, kind == cts_pkg::KIND_RUN, "non-final result is not a run")
	// Result kinds stay within the defined codes.
	`CTS_ASSERT_NOW(a_kind_range, clk, arst_n, out_valid, kind <= cts_pkg::KIND_IDLE, "undefined result kind")
	// A request is worked on alone: the next cycle after acceptance is stalled.
	`CTS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall, "request taken while busy")

endmodule

bind cooperative_task_scheduler_table_core cts_checker u_cts_checker (.*);

// ===== test/cooperative_task_scheduler_table_core_tb.sv =====
// Self-checking testbench for the cooperative task scheduler table core.
`timescale 1ns / 100ps

module cooperative_task_scheduler_table_core_tb;
	import cts_pkg::*;

	localparam int TASK_SLOTS       = 8;
	localparam int RESET_CYCLES     = 5;
	localparam int MAX_WAIT         = 14;
	// A dispatch walk plus a full stall on every run result stays far below this.
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_ITEMS     = 220;
	localparam int SATURATE_TICKS   = 257;
	localparam int DRAIN_DISPATCHES = 4;

	// One result as the block should present it.
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] slot;
		logic       last;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [2:0]  task_slot;
	logic [15:0] start_delay;
	logic [15:0] repeat_period;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [2:0]  slot_index;
	logic        last;

	// Shadow copy of the slot table, advanced once per accepted request.
	logic        slot_used      [TASK_SLOTS];
	logic [15:0] slot_countdown [TASK_SLOTS];
	logic [15:0] slot_period    [TASK_SLOTS];
	logic [7:0]  slot_pending   [TASK_SLOTS];

	// Results still owed by the block, oldest first.
	sched_result_t owed_results[$];
	sched_result_t owed_now;

	int  error_count;
	int  request_count;
	int  result_count;
	int  run_count;
	int  quiet_cycles;
	int  stall_left;
	// When set, neither side inserts idle cycles.
	bit  no_idle;

	cooperative_task_scheduler_table_core #(
		.TASK_SLOTS(TASK_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.task_slot    (task_slot),
		.start_delay  (start_delay),
		.repeat_period(repeat_period),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.slot_index   (slot_index),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle cycles that one side waits before the next request or result.
	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void owe_result(logic [2:0] k, logic [2:0] s, logic l);
		owed_results.push_back('{kind: k, slot: s, last: l});
	endfunction

	function automatic void clear_shadow_slot(int s);
		slot_used[s]      = 1'b0;
		slot_countdown[s] = '0;
		slot_period[s]    = '0;
		slot_pending[s]   = '0;
	endfunction

	// Advances the shadow table by one request and queues the results it causes.
	function automatic void predict_schedule(mode_t m, logic [2:0] sel,
			logic [15:0] delay, logic [15:0] period);
		int  ready;
		int  n;
		bit  placed;
		ready  = 0;
		n      = 0;
		placed = 1'b0;
		case (m)
			MODE_TICK: begin
				// Every used slot ages; an expiring one earns a run and reloads if periodic.
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (slot_used[s]) begin
						if (slot_countdown[s] <= 16'd1) begin
							if (slot_pending[s] != RUN_LIMIT)
								slot_pending[s]++;
							if (slot_period[s] != 16'd0)
								slot_countdown[s] = slot_period[s];
						end else begin
							slot_countdown[s]--;
						end
					end
				end
				owe_result(KIND_TICKED, 3'd0, 1'b1);
			end
			MODE_ADD: begin
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (!placed && !slot_used[s]) begin
						slot_used[s]      = 1'b1;
						slot_countdown[s] = delay;
						slot_period[s]    = period;
						slot_pending[s]   = '0;
						placed            = 1'b1;
						owe_result(KIND_ADDED, 3'(s), 1'b1);
					end
				end
				if (!placed)
					owe_result(KIND_FULL, 3'd0, 1'b1);
			end
			MODE_DELETE: begin
				// A slot number beyond the table only reports, it changes nothing.
				if (int'(sel) < TASK_SLOTS)
					clear_shadow_slot(int'(sel));
				owe_result(KIND_DELETED, sel, 1'b1);
			end
			default: begin
				// Count the ready slots first so the final run can carry last.
				for (int s = 0; s < TASK_SLOTS; s++)
					if (slot_pending[s] != 8'd0 && ready < int'(MAX_RESULTS))
						ready++;
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (n < ready && slot_pending[s] != 8'd0) begin
						slot_pending[s]--;
						// A one-shot task leaves the table once it has run.
						if (slot_period[s] == 16'd0)
							clear_shadow_slot(s);
						owe_result(KIND_RUN, 3'(s), n == ready - 1);
						n++;
					end
				end
				if (ready == 0)
					owe_result(KIND_IDLE, 3'd0, 1'b1);
			end
		endcase
	endfunction

	// Offers one request after a random gap and holds it until the block takes it.
	task automatic send_request(mode_t m, logic [2:0] sel, logic [15:0] delay,
			logic [15:0] period);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		task_slot     <= sel;
		start_delay   <= delay;
		repeat_period <= period;
		do @(posedge clk); while (in_stall);
		predict_schedule(m, sel, delay, period);
		request_count++;
	endtask

	// Holds off new requests until the block has delivered everything owed.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	// Field extremes, a full table, deletes of used and unused slots, and empty dispatches.
	task automatic test_directed_modes();
		send_request(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DISPATCH, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DELETE, 3'd7, 16'hFFFF, 16'hFFFF);
		// Delays of zero and one both make the task ready on the first tick.
		send_request(MODE_ADD, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_ADD, 3'd0, 16'h0001, 16'h0001);
		send_request(MODE_ADD, 3'd0, 16'h0002, 16'hFFFF);
		send_request(MODE_ADD, 3'd0, 16'hFFFF, 16'h5555);
		send_request(MODE_ADD, 3'd0, 16'h0003, 16'h0002);
		send_request(MODE_ADD, 3'd0, 16'h8000, 16'h0000);
		send_request(MODE_ADD, 3'd0, 16'h0000, 16'h0003);
		send_request(MODE_ADD, 3'd0, 16'h00FF, 16'hFF00);
		// The table is full now, so this add must be refused.
		send_request(MODE_ADD, 3'd5, 16'h0005, 16'h0005);
		repeat (3) send_request(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DISPATCH, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DELETE, 3'd3, 16'h0000, 16'h0000);
		send_request(MODE_DELETE, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_ADD, 3'd0, 16'h0001, 16'hAAAA);
		send_request(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DISPATCH, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DISPATCH, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DELETE, 3'd7, 16'h0000, 16'h0000);
	endtask

	// Drives the run counters into saturation, then takes a few runs off them.
	task automatic test_run_saturation();
		no_idle = 1'b1;
		for (int s = TASK_SLOTS - 1; s >= 0; s--)
			send_request(MODE_DELETE, 3'(s), 16'h0000, 16'h0000);
		// A one-shot and a period-one task both gain a run on every tick.
		send_request(MODE_ADD, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_ADD, 3'd0, 16'h0000, 16'h0001);
		no_idle = 1'b0;
		repeat (SATURATE_TICKS) send_request(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
		drain_results();
		// The one-shot is freed on its first run; the periodic one starts from its
		// saturated count and gives one run per dispatch.
		repeat (DRAIN_DISPATCHES)
			send_request(MODE_DISPATCH, 3'd0, 16'h0000, 16'h0000);
		send_request(MODE_DELETE, 3'd1, 16'h0000, 16'h0000);
	endtask

	// Random mix of requests with mostly short delays so tasks keep firing.
	task automatic test_random_traffic();
		int          pick;
		mode_t       m;
		logic [15:0] delay;
		logic [15:0] period;
		drain_results();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (i % 75 == 74)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 40)
				m = MODE_TICK;
			else if (pick < 62)
				m = MODE_ADD;
			else if (pick < 77)
				m = MODE_DELETE;
			else
				m = MODE_DISPATCH;
			delay  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6))
				: 16'($urandom);
			pick   = $urandom_range(0, 9);
			period = (pick < 3) ? 16'h0000
				: (pick < 7) ? 16'($urandom_range(1, 8)) : 16'($urandom);
			send_request(m, 3'($urandom_range(0, 7)), delay, period);
		end
		no_idle = 1'b0;
	endtask

	// Result side: checks every accepted result and draws its own stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (kind == KIND_RUN)
					run_count++;
				if (owed_results.size() == 0) begin
					$error("result with nothing owed: kind %0d slot_index %0d last %0d",
						kind, slot_index, last);
					error_count++;
				end else begin
					owed_now = owed_results.pop_front();
					if (kind !== owed_now.kind) begin
						$error("kind: expected %0d, got %0d", owed_now.kind, kind);
						error_count++;
					end
					if (slot_index !== owed_now.slot) begin
						$error("slot_index: expected %0d, got %0d", owed_now.slot, slot_index);
						error_count++;
					end
					if (last !== owed_now.last) begin
						$error("last: expected %0d, got %0d", owed_now.last, last);
						error_count++;
					end
				end
				stall_left = draw_wait();
			end else if (out_valid && stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	// Watchdog: too long without any handshake on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles, %0d results still owed.",
					quiet_cycles, owed_results.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		error_count   = 0;
		request_count = 0;
		result_count  = 0;
		run_count     = 0;
		quiet_cycles  = 0;
		stall_left    = 0;
		no_idle       = 1'b0;
		for (int s = 0; s < TASK_SLOTS; s++)
			clear_shadow_slot(s);
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_TICK;
		task_slot     <= '0;
		start_delay   <= '0;
		repeat_period <= '0;
		out_stall     <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_modes();
		test_run_saturation();
		test_random_traffic();

		// Let the last results out, then give stray ones a chance to show up.
		drain_results();
		repeat (TASK_SLOTS + 8) @(posedge clk);

		$display("Sent %0d requests and checked %0d results, %0d of them task runs.",
			request_count, result_count, run_count);
		$display("Covered full-table adds, deletes, empty dispatches and run count saturation.");
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
